@@ rtl/core/pfc_pkg.sv @@
// pfc_pkg: shared types, register indexes and helper functions for the pixel format converter
`timescale 1ns / 1ps

package pfc_pkg;

    typedef logic [7:0]  comp_t;
    typedef logic [3:0]  width_t;
    typedef logic [4:0]  shift_t;
    typedef logic [35:0] layout_t;
    typedef logic [2:0]  reg_idx_t;

    // one packed component slot: shift and effective width
    typedef struct packed {
        shift_t sh;
        width_t w;
    } field_t;

    // request into a rescale lane
    typedef struct packed {
        comp_t  v;
        width_t sw;
        width_t dw;
    } rsc_req_t;

    localparam reg_idx_t REG_SRC_LAYOUT = 3'd0;
    localparam reg_idx_t REG_DST_LAYOUT = 3'd1;
    localparam reg_idx_t REG_SRC_BYTES  = 3'd2;
    localparam reg_idx_t REG_DST_BYTES  = 3'd3;
    localparam reg_idx_t REG_OPTIONS    = 3'd4;
    localparam reg_idx_t REG_KEY_LOW    = 3'd5;
    localparam reg_idx_t REG_KEY_HIGH   = 3'd6;

    localparam int OPT_ALPHA_TO_RGB = 0;
    localparam int OPT_INVERT_ALPHA = 1;
    localparam int OPT_COLOR_KEY    = 2;

    localparam int COMP_R = 0;
    localparam int COMP_G = 1;
    localparam int COMP_B = 2;
    localparam int COMP_A = 3;

    localparam int     NUM_COMP   = 4;
    localparam width_t FULL_WIDTH = 4'd8;
    localparam int     RECIP_BITS = 26;

    localparam comp_t  ALPHA_OPAQUE = 8'hFF;
    localparam comp_t  ALPHA_CLEAR  = 8'h00;

    // shift and width of component c, width clamped to 8 and to the word
    function automatic field_t field_of(input layout_t lay, input int c);
        logic [8:0] bits;
        field_t     f;
        logic [5:0] room;
        bits = 9'(lay >> (9 * c));
        f.sh = bits[4:0];
        f.w  = (bits[8:5] > FULL_WIDTH) ? FULL_WIDTH : bits[8:5];
        room = 6'd32 - 6'(f.sh);
        if (6'(f.w) > room)
        begin
            f.w = 4'(room);
        end
        return f;
    endfunction

    // mask of the valid bytes of a pixel; zero acts as one, five and up as four
    function automatic logic [31:0] byte_mask(input logic [2:0] b);
        logic [31:0] m;
        case (b) inside
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            [3'd4:3'd7]: m = 32'hFFFF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // all-ones value of a component of width w
    function automatic comp_t comp_max(input width_t w);
        logic [8:0] t;
        t = (9'd1 << w) - 9'd1;
        return comp_t'(t);
    endfunction

    // ceil(2^26 / (2 * (2^sw - 1))): exact quotient for numerators below 2^17
    function automatic logic [RECIP_BITS-1:0] recip(input width_t sw);
        logic [RECIP_BITS-1:0] r;
        case (sw)
            4'd1:    r = 26'd33554432;
            4'd2:    r = 26'd11184811;
            4'd3:    r = 26'd4793491;
            4'd4:    r = 26'd2236963;
            4'd5:    r = 26'd1082402;
            4'd6:    r = 26'd532611;
            4'd7:    r = 26'd264209;
            4'd8:    r = 26'd131587;
            default: r = 26'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/pfc_rescale.sv @@
// pfc_rescale: two-stage lane computing round(v * dmax / smax) by reciprocal multiply
`timescale 1ns / 1ps

module pfc_rescale
    import pfc_pkg::*;
(
    input  logic     clk,
    input  rsc_req_t req,
    output comp_t    q
);

    localparam int NUM_BITS  = 17;
    localparam int PROD_BITS = NUM_BITS + RECIP_BITS;

    logic [NUM_BITS-1:0]  num_reg, num_next;
    width_t               sw_reg;
    comp_t                dmax_reg, dmax_next;
    logic [15:0]          vd;
    logic [PROD_BITS-1:0] prod;
    comp_t                q_reg, q_next;

    // numerator 2*v*dmax + smax
    always_comb
    begin
        dmax_next = comp_max(req.dw);
        vd        = req.v * dmax_next;
        num_next  = {vd, 1'b0} + NUM_BITS'(comp_max(req.sw));
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        sw_reg   <= req.sw;
        dmax_reg <= dmax_next;
    end

    // divide by 2*smax via reciprocal; missing source component gives full scale
    always_comb
    begin
        prod = PROD_BITS'(num_reg) * PROD_BITS'(recip(sw_reg));
        if (sw_reg == 4'd0)
        begin
            q_next = dmax_reg;
        end
        else
        begin
            q_next = prod[RECIP_BITS+7:RECIP_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/core/pixel_format_converter.sv @@
// pixel_format_converter: top level, config registers and seven-stage conversion pipeline
`timescale 1ns / 1ps

// channel   | ports                               | handshake
// ----------+-------------------------------------+-------------------------------
// input     | start, busy, src_pixel[31:0]        | word taken when start && !busy
// result    | done, dst_pixel[31:0]               | word valid for one cycle on done
// config    | cfg_we, cfg_index[2:0], cfg_data    | register written when cfg_we
//
// one word accepted every clock; busy is never raised
// result path after acceptance: input stage, two rescale lanes of two
//   multiplier stages each, an option stage and the output register
// reset clears the valid line and loads config defaults; payload registers are not reset
// the receiver cannot stall, so results leave on the cycle their valid bit arrives

module pixel_format_converter
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] src_pixel,
    output logic        done,
    output logic [31:0] dst_pixel,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_data
);

    localparam int DEPTH = 7;

    // config registers
    layout_t     src_layout_reg;
    layout_t     dst_layout_reg;
    logic [2:0]  src_bytes_reg;
    logic [2:0]  dst_bytes_reg;
    logic [2:0]  option_flags_reg;
    logic [23:0] key_low_reg;
    logic [23:0] key_high_reg;

    // valid line, bit 0 is the input stage and the top bit drives done
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic             accept;

    // raw pixel carried for the pass-through case, stages one to six
    logic [31:0] pix_reg [0:5];

    // raw components carried beside the first rescale lane
    comp_t  vraw_reg [0:1][NUM_COMP];
    width_t wraw_reg [0:1][NUM_COMP];

    // option stage outputs
    comp_t  v4_reg [NUM_COMP];
    width_t w4_reg [NUM_COMP];
    comp_t  v4_next [NUM_COMP];
    width_t w4_next [NUM_COMP];

    comp_t    v1 [NUM_COMP];
    width_t   w1 [NUM_COMP];
    comp_t    q1 [NUM_COMP];
    comp_t    q2 [NUM_COMP];
    rsc_req_t req1 [NUM_COMP];
    rsc_req_t req2 [NUM_COMP];

    field_t      src_f [NUM_COMP];
    field_t      dst_f [NUM_COMP];
    logic        keep  [NUM_COMP];

    logic        raw_mode;
    logic        key_hit;
    logic [31:0] packed_out;
    logic [31:0] dst_pixel_reg, dst_pixel_next;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    // ---------------------------------------------------------------
    // configuration write port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_layout_reg   <= '0;
            dst_layout_reg   <= '0;
            src_bytes_reg    <= 3'd4;
            dst_bytes_reg    <= 3'd4;
            option_flags_reg <= 3'd0;
            key_low_reg      <= 24'hF000F0;
            key_high_reg     <= 24'hFF0FFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_LAYOUT: src_layout_reg   <= cfg_data;
                REG_DST_LAYOUT: dst_layout_reg   <= cfg_data;
                REG_SRC_BYTES:  src_bytes_reg    <= cfg_data[2:0];
                REG_DST_BYTES:  dst_bytes_reg    <= cfg_data[2:0];
                REG_OPTIONS:    option_flags_reg <= cfg_data[2:0];
                REG_KEY_LOW:    key_low_reg      <= cfg_data[23:0];
                REG_KEY_HIGH:   key_high_reg     <= cfg_data[23:0];
                default:        ;
            endcase
        end
    end

    // config-derived decode; the user must keep it static while words are in flight, the block does not enforce it
    always_comb
    begin
        logic [31:0] written;
        logic [31:0] dmask;
        written  = '0;
        raw_mode = (option_flags_reg == 3'd0) && (src_layout_reg == dst_layout_reg)
                   && (src_bytes_reg == dst_bytes_reg);
        for (int c = 0; c < NUM_COMP; c++)
        begin
            src_f[c] = field_of(src_layout_reg, c);
            dst_f[c] = field_of(dst_layout_reg, c);
            // later components that overlap earlier ones are dropped
            dmask    = 32'(comp_max(dst_f[c].w)) << dst_f[c].sh;
            keep[c]  = ((written & dmask) == 32'd0);
            if (keep[c])
            begin
                written = written | dmask;
            end
        end
    end

    // ---------------------------------------------------------------
    // valid line
    // ---------------------------------------------------------------
    assign vld_next = {vld_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: input register, source bytes masked off
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pix_reg[0] <= src_pixel & byte_mask(src_bytes_reg);
        for (int s = 1; s < 6; s++)
        begin
            pix_reg[s] <= pix_reg[s-1];
        end
    end

    // extract components; first lane rescales to 8 bits
    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            w1[c]      = src_f[c].w;
            v1[c]      = comp_t'(pix_reg[0] >> src_f[c].sh) & comp_max(src_f[c].w);
            req1[c].v  = v1[c];
            req1[c].sw = w1[c];
            req1[c].dw = FULL_WIDTH;
        end
    end

    // ---------------------------------------------------------------
    // stages 2-3: rescale to 8-bit rgba, raw values ride alongside
    // ---------------------------------------------------------------
    generate
        for (genvar g = 0; g < NUM_COMP; g++)
        begin : g_lane1
            pfc_rescale u_rsc1
            (
                .clk (clk),
                .req (req1[g]),
                .q   (q1[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            vraw_reg[0][c] <= v1[c];
            wraw_reg[0][c] <= w1[c];
            vraw_reg[1][c] <= vraw_reg[0][c];
            wraw_reg[1][c] <= wraw_reg[0][c];
        end
    end

    // ---------------------------------------------------------------
    // option stage: alpha to rgb, invert alpha, color key
    // ---------------------------------------------------------------
    always_comb
    begin
        comp_t t [NUM_COMP];
        for (int c = 0; c < NUM_COMP; c++)
        begin
            t[c] = q1[c];
        end
        if (option_flags_reg[OPT_ALPHA_TO_RGB])
        begin
            t[COMP_R] = q1[COMP_A];
            t[COMP_G] = q1[COMP_A];
            t[COMP_B] = q1[COMP_A];
        end
        if (option_flags_reg[OPT_INVERT_ALPHA])
        begin
            t[COMP_A] = ALPHA_OPAQUE - t[COMP_A];
        end
        key_hit = (t[COMP_R] >= key_low_reg[23:16]) && (t[COMP_R] <= key_high_reg[23:16])
               && (t[COMP_G] >= key_low_reg[15:8])  && (t[COMP_G] <= key_high_reg[15:8])
               && (t[COMP_B] >= key_low_reg[7:0])   && (t[COMP_B] <= key_high_reg[7:0]);
        if (option_flags_reg[OPT_COLOR_KEY])
        begin
            t[COMP_A] = key_hit ? ALPHA_CLEAR : ALPHA_OPAQUE;
        end
        for (int c = 0; c < NUM_COMP; c++)
        begin
            // without options the source value goes straight to the destination lane
            if (option_flags_reg != 3'd0)
            begin
                v4_next[c] = t[c];
                w4_next[c] = FULL_WIDTH;
            end
            else
            begin
                v4_next[c] = vraw_reg[1][c];
                w4_next[c] = wraw_reg[1][c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            v4_reg[c] <= v4_next[c];
            w4_reg[c] <= w4_next[c];
        end
    end

    // ---------------------------------------------------------------
    // stages 5-6: rescale to destination widths
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            req2[c].v  = v4_reg[c];
            req2[c].sw = w4_reg[c];
            req2[c].dw = dst_f[c].w;
        end
    end

    generate
        for (genvar g = 0; g < NUM_COMP; g++)
        begin : g_lane2
            pfc_rescale u_rsc2
            (
                .clk (clk),
                .req (req2[g]),
                .q   (q2[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // stage 7: pack or pass the raw pixel through, mask destination bytes, output register
    // ---------------------------------------------------------------
    always_comb
    begin
        packed_out = '0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            if (keep[c])
            begin
                packed_out = packed_out | (32'(q2[c]) << dst_f[c].sh);
            end
        end
        if (raw_mode)
        begin
            dst_pixel_next = pix_reg[5] & byte_mask(dst_bytes_reg);
        end
        else
        begin
            dst_pixel_next = packed_out & byte_mask(dst_bytes_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        dst_pixel_reg <= dst_pixel_next;
    end

    assign done      = vld_reg[DEPTH-1];
    assign dst_pixel = dst_pixel_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // every accepted word comes out on done once it has passed the whole valid line
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, DEPTH) && $past(rst_n, 1)) |-> (done == $past(accept, DEPTH)))
        else $error("result strobe out of step with accepted words");

    // color keying leaves alpha fully clear or fully opaque
    a_key_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && option_flags_reg[OPT_COLOR_KEY])
        |-> (v4_reg[COMP_A] == ALPHA_CLEAR || v4_reg[COMP_A] == ALPHA_OPAQUE))
        else $error("color key produced partial alpha");

    // destination lanes never exceed the destination component range
    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> ((q2[COMP_R] <= comp_max(dst_f[COMP_R].w))
                     && (q2[COMP_G] <= comp_max(dst_f[COMP_G].w))
                     && (q2[COMP_B] <= comp_max(dst_f[COMP_B].w))
                     && (q2[COMP_A] <= comp_max(dst_f[COMP_A].w))))
        else $error("rescaled component above destination maximum");

    // in option mode the red and alpha inputs to the second lane keep the 8-bit width
    a_opt_width: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && option_flags_reg != 3'd0)
        |-> (w4_reg[COMP_R] == FULL_WIDTH && w4_reg[COMP_A] == FULL_WIDTH))
        else $error("option path lost 8-bit intermediate width");

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for the pixel format converter, directed cases then random configs and pixels
`timescale 1ns / 1ps

module tb_top
    import pfc_pkg::*;
;

    // pipeline depth from the block head, used for the final quiet period
    localparam int LATENCY       = 7;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int REPORT_LIMIT  = 10;

    // register values after reset
    localparam logic [2:0]  BYTES_RESET    = 3'd4;
    localparam logic [23:0] KEY_LOW_RESET  = 24'hF000F0;
    localparam logic [23:0] KEY_HIGH_RESET = 24'hFF0FFF;

    // index with no register behind it, writes there must change nothing
    localparam reg_idx_t REG_UNUSED = 3'd7;

    // one accepted word and the pixel the converter should produce for it
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
    } conv_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] src_pixel = '0;
    logic        done;
    logic [31:0] dst_pixel;
    logic        cfg_we = 1'b0;
    reg_idx_t    cfg_index = REG_SRC_LAYOUT;
    logic [35:0] cfg_data = '0;

    // pixels waiting for the driver, and conversions waiting for the monitor
    logic [31:0] pending_pixels[$];
    conv_t       expected_conv[$];

    // converter settings as the block should hold them
    layout_t     cur_src_layout;
    layout_t     cur_dst_layout;
    logic [2:0]  cur_src_bytes;
    logic [2:0]  cur_dst_bytes;
    logic [2:0]  cur_opts;
    logic [23:0] cur_key_lo;
    logic [23:0] cur_key_hi;

    int fail_count = 0;
    int gap_left   = 0;
    int burst_left = 0;
    conv_t head_conv;

    pixel_format_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .src_pixel (src_pixel),
        .done      (done),
        .dst_pixel (dst_pixel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // shift and usable width of one component slot
    // widths above 8 act as 8, and a slot is cut off at bit 31
    function automatic void slot_of(input layout_t lay, input int c,
                                    output int unsigned sh, output int unsigned w);
        logic [8:0] bits;
        bits = 9'(lay >> (9 * c));
        sh   = bits[4:0];
        w    = bits[8:5];
        if (w > 8)
        begin
            w = 8;
        end
        if (w > 32 - sh)
        begin
            w = 32 - sh;
        end
    endfunction

    // round(v * dmax / smax), halves up; a missing source gives full scale
    function automatic logic [7:0] scale_comp(input logic [7:0] v, input int unsigned sw,
                                              input int unsigned dw);
        int unsigned dmax;
        int unsigned smax;
        dmax = (32'd1 << dw) - 1;
        if (sw == 0)
        begin
            return 8'(dmax);
        end
        smax = (32'd1 << sw) - 1;
        return 8'((2 * int'(v) * dmax + smax) / (2 * smax));
    endfunction

    // valid bytes of a pixel: zero counts as one, five and up as four
    function automatic logic [31:0] bytes_mask(input logic [2:0] b);
        int unsigned n;
        n = (b == 3'd0) ? 1 : ((b > 3'd4) ? 4 : int'(b));
        if (n == 4)
        begin
            return 32'hFFFF_FFFF;
        end
        return (32'd1 << (8 * n)) - 1;
    endfunction

    // full conversion of one source word under the current settings
    function automatic logic [31:0] convert_pixel(input logic [31:0] raw);
        logic [31:0] px;
        logic [31:0] outw;
        logic [31:0] written;
        logic [31:0] dmask;
        logic [7:0]  v [NUM_COMP];
        int unsigned w [NUM_COMP];
        int unsigned sh;
        int unsigned ds;
        int unsigned dw;
        logic        hit;
        logic [7:0]  lo;
        logic [7:0]  hi;
        px = raw & bytes_mask(cur_src_bytes);
        // identical formats and no options: raw copy, still byte masked
        if (cur_opts == 3'd0 && cur_src_layout == cur_dst_layout &&
            cur_src_bytes == cur_dst_bytes)
        begin
            return px & bytes_mask(cur_dst_bytes);
        end
        for (int c = 0; c < NUM_COMP; c++)
        begin
            slot_of(cur_src_layout, c, sh, w[c]);
            v[c] = 8'((px >> sh) & ((32'd1 << w[c]) - 1));
        end
        if (cur_opts != 3'd0)
        begin
            // options work on 8-bit rgba
            for (int c = 0; c < NUM_COMP; c++)
            begin
                v[c] = scale_comp(v[c], w[c], 8);
                w[c] = 8;
            end
            if (cur_opts[OPT_ALPHA_TO_RGB])
            begin
                v[COMP_R] = v[COMP_A];
                v[COMP_G] = v[COMP_A];
                v[COMP_B] = v[COMP_A];
            end
            if (cur_opts[OPT_INVERT_ALPHA])
            begin
                v[COMP_A] = ALPHA_OPAQUE - v[COMP_A];
            end
            if (cur_opts[OPT_COLOR_KEY])
            begin
                hit = 1'b1;
                for (int c = COMP_R; c <= COMP_B; c++)
                begin
                    lo = 8'(cur_key_lo >> (16 - 8 * c));
                    hi = 8'(cur_key_hi >> (16 - 8 * c));
                    if (v[c] < lo || v[c] > hi)
                    begin
                        hit = 1'b0;
                    end
                end
                v[COMP_A] = hit ? ALPHA_CLEAR : ALPHA_OPAQUE;
            end
        end
        // place components in r, g, b, a order; a slot hitting earlier bits is dropped
        written = '0;
        outw    = '0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            slot_of(cur_dst_layout, c, ds, dw);
            dmask = ((32'd1 << dw) - 1) << ds;
            if ((written & dmask) != 0)
            begin
                continue;
            end
            written |= dmask;
            outw    |= 32'(scale_comp(v[c], w[c], dw)) << ds;
        end
        return outw & bytes_mask(cur_dst_bytes);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // layout register from per-component shift and width
    function automatic layout_t pack_layout(input int unsigned sr, input int unsigned wr,
                                            input int unsigned sg, input int unsigned wg,
                                            input int unsigned sb, input int unsigned wb,
                                            input int unsigned sa, input int unsigned wa);
        return {4'(wa), 5'(sa), 4'(wb), 5'(sb), 4'(wg), 5'(sg), 4'(wr), 5'(sr)};
    endfunction

    // mostly real pixel formats, sometimes odd or fully random layouts
    function automatic void pick_format(output layout_t lay, output logic [2:0] nbytes);
        case ($urandom_range(0, 13))
            0:
            begin
                lay = pack_layout(0, 8, 8, 8, 16, 8, 24, 8);
                nbytes = 3'd4;
            end
            1:
            begin
                lay = pack_layout(16, 8, 8, 8, 0, 8, 24, 8);
                nbytes = 3'd4;
            end
            2:
            begin
                lay = pack_layout(8, 8, 16, 8, 24, 8, 0, 8);
                nbytes = 3'd4;
            end
            3:
            begin
                lay = pack_layout(11, 5, 5, 6, 0, 5, 0, 0);
                nbytes = 3'd2;
            end
            4:
            begin
                lay = pack_layout(10, 5, 5, 5, 0, 5, 15, 1);
                nbytes = 3'd2;
            end
            5:
            begin
                lay = pack_layout(12, 4, 8, 4, 4, 4, 0, 4);
                nbytes = 3'd2;
            end
            6:
            begin
                lay = pack_layout(0, 8, 8, 8, 16, 8, 0, 0);
                nbytes = 3'd3;
            end
            7:
            begin
                lay = pack_layout(0, 0, 0, 0, 0, 0, 0, 8);
                nbytes = 3'd1;
            end
            8:
            begin
                lay = pack_layout(5, 3, 2, 3, 0, 2, 0, 0);
                nbytes = 3'd1;
            end
            9:
            begin
                lay = '0;
                nbytes = 3'($urandom_range(0, 7));
            end
            10:
            begin
                lay = '1;
                nbytes = 3'($urandom_range(0, 7));
            end
            11:
            begin
                lay = pack_layout($urandom_range(0, 31), $urandom_range(0, 8),
                                  $urandom_range(0, 31), $urandom_range(0, 8),
                                  $urandom_range(0, 31), $urandom_range(0, 8),
                                  $urandom_range(0, 31), $urandom_range(0, 8));
                nbytes = 3'($urandom_range(1, 4));
            end
            default:
            begin
                lay = {4'($urandom), 32'($urandom)};
                nbytes = 3'($urandom_range(0, 7));
            end
        endcase
    endfunction

    // sometimes set the bits above a narrow register, which must be dropped
    function automatic logic [35:0] noisy(input logic [35:0] val, input int width);
        logic [35:0] junk;
        junk = {4'($urandom), 32'($urandom)};
        if ($urandom_range(0, 3) != 0)
        begin
            return val;
        end
        return (junk << width) | val;
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // one register write; consecutive calls keep cfg_we high across cycles
    task automatic write_reg(input reg_idx_t idx, input logic [35:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        // nothing is in flight during writes, so the predictor can follow at once
        case (idx)
            REG_SRC_LAYOUT: cur_src_layout = data;
            REG_DST_LAYOUT: cur_dst_layout = data;
            REG_SRC_BYTES:  cur_src_bytes  = data[2:0];
            REG_DST_BYTES:  cur_dst_bytes  = data[2:0];
            REG_OPTIONS:    cur_opts       = data[2:0];
            REG_KEY_LOW:    cur_key_lo     = data[23:0];
            REG_KEY_HIGH:   cur_key_hi     = data[23:0];
            default:        ;
        endcase
    endtask

    // close a burst of writes; words are queued after the next rising edge
    task automatic finish_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every queued word is taken and every result is back
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_pixels.size() != 0 || expected_conv.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps, idle data is junk
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || pending_pixels.size() == 0)
        begin
            start     <= 1'b0;
            src_pixel <= $urandom;
        end
        else if (gap_left > 0)
        begin
            gap_left  = gap_left - 1;
            start     <= 1'b0;
            src_pixel <= $urandom;
        end
        else
        begin
            start     <= 1'b1;
            src_pixel <= pending_pixels[0];
            // end of burst: pick the next gap, often none for long stretches
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
            begin
                burst_left = burst_left - 1;
            end
        end
    end

    // word taken on start && !busy: predict its result right away
    always @(posedge clk)
    begin
        if (rst_n && start && !busy && pending_pixels.size() != 0)
        begin
            expected_conv.push_back({pending_pixels[0], convert_pixel(pending_pixels[0])});
            void'(pending_pixels.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // monitor: each done strobe is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_conv.size() == 0)
            begin
                report_failure($sformatf("unexpected result %h", dst_pixel));
            end
            else
            begin
                head_conv = expected_conv.pop_front();
                if (dst_pixel !== head_conv.dst)
                begin
                    report_failure($sformatf("src %h: expected %h, got %h",
                                             head_conv.src, head_conv.dst, dst_pixel));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          sent;
        int          n;
        layout_t     sl;
        layout_t     dl;
        logic [2:0]  sb;
        logic [2:0]  db;
        logic [2:0]  opts;
        logic [23:0] klo;
        logic [23:0] khi;
        logic [7:0]  clo;
        logic [7:0]  chi;

        // settings the block loads on reset
        cur_src_layout = '0;
        cur_dst_layout = '0;
        cur_src_bytes  = BYTES_RESET;
        cur_dst_bytes  = BYTES_RESET;
        cur_opts       = 3'd0;
        cur_key_lo     = KEY_LOW_RESET;
        cur_key_hi     = KEY_HIGH_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: equal layouts and byte counts, raw copy
        @(posedge clk);
        pending_pixels.push_back(32'h0000_0000);
        pending_pixels.push_back(32'hFFFF_FFFF);
        pending_pixels.push_back(32'h1234_5678);
        wait_drained();

        // raw copy with two-byte pixels, upper bytes cleared
        write_reg(REG_SRC_BYTES, 36'd2);
        write_reg(REG_DST_BYTES, 36'd2);
        finish_writes();
        pending_pixels.push_back(32'hFFFF_FFFF);
        pending_pixels.push_back(32'hA5C3_5A3C);
        wait_drained();

        // rgba8888 down to rgb565, rounding at mid scale
        write_reg(REG_SRC_LAYOUT, pack_layout(0, 8, 8, 8, 16, 8, 24, 8));
        write_reg(REG_DST_LAYOUT, pack_layout(11, 5, 5, 6, 0, 5, 0, 0));
        write_reg(REG_SRC_BYTES, 36'd4);
        finish_writes();
        pending_pixels.push_back(32'h0000_0000);
        pending_pixels.push_back(32'hFFFF_FFFF);
        pending_pixels.push_back(32'h0080_8080);
        pending_pixels.push_back(32'h7F01_FF80);
        wait_drained();

        // rgb565 up to rgba8888: missing alpha comes out full, high input bytes ignored
        write_reg(REG_SRC_LAYOUT, pack_layout(11, 5, 5, 6, 0, 5, 0, 0));
        write_reg(REG_DST_LAYOUT, pack_layout(0, 8, 8, 8, 16, 8, 24, 8));
        write_reg(REG_SRC_BYTES, 36'd2);
        write_reg(REG_DST_BYTES, 36'd4);
        finish_writes();
        pending_pixels.push_back(32'h1234_F81F);
        pending_pixels.push_back(32'h0000_FFFF);
        pending_pixels.push_back(32'h0000_0000);
        wait_drained();

        // odd corners: width over 8, slots past bit 31, overlapping destination slot,
        // byte count zero on the source and seven on the destination
        write_reg(REG_SRC_LAYOUT, pack_layout(0, 15, 4, 8, 30, 8, 31, 9));
        write_reg(REG_DST_LAYOUT, pack_layout(0, 8, 4, 8, 28, 8, 8, 4));
        write_reg(REG_SRC_BYTES, 36'd0);
        write_reg(REG_DST_BYTES, 36'd7);
        finish_writes();
        pending_pixels.push_back(32'hFFFF_FFFF);
        pending_pixels.push_back(32'h0000_00C3);
        wait_drained();

        // alpha copied into rgb
        write_reg(REG_SRC_LAYOUT, pack_layout(0, 8, 8, 8, 16, 8, 24, 8));
        write_reg(REG_DST_LAYOUT, pack_layout(0, 8, 8, 8, 16, 8, 24, 8));
        write_reg(REG_SRC_BYTES, 36'd4);
        write_reg(REG_DST_BYTES, 36'd4);
        write_reg(REG_OPTIONS, 36'(1 << OPT_ALPHA_TO_RGB));
        finish_writes();
        pending_pixels.push_back(32'h8011_2233);
        pending_pixels.push_back(32'hFF00_0000);
        wait_drained();

        // alpha inverted
        write_reg(REG_OPTIONS, 36'(1 << OPT_INVERT_ALPHA));
        finish_writes();
        pending_pixels.push_back(32'h00FF_FFFF);
        pending_pixels.push_back(32'hFF00_0000);
        wait_drained();

        // color key with the reset bounds: inside, outside on green, on the edges
        write_reg(REG_OPTIONS, 36'(1 << OPT_COLOR_KEY));
        finish_writes();
        pending_pixels.push_back(32'h00F0_08F8);
        pending_pixels.push_back(32'h00F0_10F8);
        pending_pixels.push_back(32'h12FF_0FF0);
        wait_drained();

        // all options with a single-color key: alpha copy feeds the key test
        write_reg(REG_OPTIONS, 36'd7);
        write_reg(REG_KEY_LOW, 36'h40_4040);
        write_reg(REG_KEY_HIGH, 36'h40_4040);
        finish_writes();
        pending_pixels.push_back(32'h4000_0000);
        pending_pixels.push_back(32'h4100_0000);
        wait_drained();

        // empty red range keys nothing; a write to the unused index changes nothing
        write_reg(REG_OPTIONS, 36'(1 << OPT_COLOR_KEY));
        write_reg(REG_KEY_LOW, 36'h80_8080);
        write_reg(REG_KEY_HIGH, 36'h7F_FFFF);
        write_reg(REG_UNUSED, {4'hF, 32'($urandom)});
        finish_writes();
        pending_pixels.push_back(32'h0080_8080);
        wait_drained();

        // random phases: new settings each time, then a run of pixels
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick_format(sl, sb);
            // now and then the same format on both sides, to reach the raw copy
            if ($urandom_range(0, 5) == 0)
            begin
                dl = sl;
                db = sb;
            end
            else
            begin
                pick_format(dl, db);
            end
            if ($urandom_range(0, 5) == 0)
            begin
                sb = 3'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                db = 3'($urandom_range(0, 7));
            end
            opts = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(1, 7));

            // key bounds: everything, ordered per channel, random, or a single color
            case ($urandom_range(0, 4))
                0:
                begin
                    klo = 24'h00_0000;
                    khi = 24'hFF_FFFF;
                end
                1, 2:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        clo = 8'($urandom_range(0, 255));
                        chi = 8'($urandom_range(clo, 255));
                        klo[8 * c +: 8] = clo;
                        khi[8 * c +: 8] = chi;
                    end
                end
                3:
                begin
                    klo = 24'($urandom);
                    khi = 24'($urandom);
                end
                default:
                begin
                    klo = 24'($urandom);
                    khi = klo;
                end
            endcase

            write_reg(REG_SRC_LAYOUT, sl);
            write_reg(REG_DST_LAYOUT, dl);
            write_reg(REG_SRC_BYTES, noisy(36'(sb), 3));
            write_reg(REG_DST_BYTES, noisy(36'(db), 3));
            write_reg(REG_OPTIONS, noisy(36'(opts), 3));
            write_reg(REG_KEY_LOW, noisy(36'(klo), 24));
            write_reg(REG_KEY_HIGH, noisy(36'(khi), 24));
            if ($urandom_range(0, 15) == 0)
            begin
                write_reg(REG_UNUSED, {4'($urandom), 32'($urandom)});
            end
            finish_writes();

            n = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 150) : $urandom_range(10, 50);
            for (int i = 0; i < n; i++)
            begin
                pending_pixels.push_back(rand_pixel());
            end
            sent += n;
            wait_drained();
        end

        // quiet period: any stray strobe here is a failure in the monitor
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0 && expected_conv.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
